[rtl/pcbs_pkg.sv]
// ----------------------------------------------------------------------------
// pcbs_pkg: shared types and constants
// Request and result transaction types, request codes, register indexes,
// sequencer states and default sizes for the box suppression unit.
// ----------------------------------------------------------------------------
package pcbs_pkg;

    localparam int MAX_DETS_DEF    = 256;
    localparam int MAX_CLASSES_DEF = 128;
    localparam int COORD_BITS_DEF  = 16;

    // digit width of the shared multiply-accumulate unit
    localparam int MAC_DIGIT = 16;

    localparam logic [15:0] THR_RESET  = 16'd29491;
    localparam logic [7:0]  NCLS_RESET = 8'd80;

    localparam logic CFG_IOU_THR = 1'b0;
    localparam logic CFG_NUM_CLS = 1'b1;

    localparam logic STS_OK  = 1'b0;
    localparam logic STS_ERR = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD_BOX   = 2'd0,
        REQ_LOAD_SCORE = 2'd1,
        REQ_RUN        = 2'd2,
        REQ_READ       = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_A_RD,
        S_A_LD,
        S_A_AREA,
        S_B_RD,
        S_B_EV,
        S_M_INT,
        S_M_AREA,
        S_M_THR
    } t_state;

    typedef struct packed {
        t_req               req_type;
        logic [7:0]         det_index;
        logic [6:0]         class_index;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic [15:0]        score_in;
        logic [8:0]         det_count;
    } t_in;

    typedef struct packed {
        logic [15:0] score_out;
        logic        status;
    } t_out;

endpackage

[rtl/pcbs_mac.sv]
// ----------------------------------------------------------------------------
// pcbs_mac: shared multiply-accumulate unit
// Multiplies a wide operand by a narrower one, one 16-bit digit of the
// narrow operand per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module pcbs_mac
    import pcbs_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WA-1:0]     i_a,
    input  logic [WB-1:0]     i_b,
    output logic              o_done,
    output logic [WA+WB-1:0]  o_prod
);

    localparam int ND  = WB / MAC_DIGIT;
    localparam int CNW = $clog2(ND + 1);
    localparam int PW  = WA + WB;

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [WA-1:0]  r_a;
    logic [WB-1:0]  r_b;
    logic [PW-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(ND);
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                // shift in the next partial product
                r_acc <= (r_acc << MAC_DIGIT) + PW'(r_a * r_b[WB-1 -: MAC_DIGIT]);
                r_b   <= r_b << MAC_DIGIT;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[rtl/pcbs_mem.sv]
// ----------------------------------------------------------------------------
// pcbs_mem: box and score storage
// One write and one registered read port per memory.
// ----------------------------------------------------------------------------
module pcbs_mem
    import pcbs_pkg::*;
#(
    parameter int DW   = 8,
    parameter int CW   = 7,
    parameter int BOXW = 62
) (
    input  logic              i_clk,
    input  logic              i_box_we,
    input  logic              i_box_re,
    input  logic [DW-1:0]     i_box_addr,
    input  logic [BOXW-1:0]   i_box_wdata,
    output logic [BOXW-1:0]   o_box_q,
    input  logic              i_sc_we,
    input  logic              i_sc_re,
    input  logic [DW+CW-1:0]  i_sc_addr,
    input  logic [15:0]       i_sc_wdata,
    output logic [15:0]       o_sc_q
);

    logic [BOXW-1:0] box_mem [0:(2**DW)-1];
    logic [15:0]     sc_mem  [0:(2**(DW+CW))-1];
    logic [BOXW-1:0] r_box_q;
    logic [15:0]     r_sc_q;

    always_ff @(posedge i_clk) begin
        if (i_box_we) begin
            box_mem[i_box_addr] <= i_box_wdata;
        end
        if (i_box_re) begin
            r_box_q <= box_mem[i_box_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sc_we) begin
            sc_mem[i_sc_addr] <= i_sc_wdata;
        end
        if (i_sc_re) begin
            r_sc_q <= sc_mem[i_sc_addr];
        end
    end

    assign o_box_q = r_box_q;
    assign o_sc_q  = r_sc_q;

endmodule

[rtl/per_class_box_suppression_unit.sv]
// ----------------------------------------------------------------------------
// per_class_box_suppression_unit: greedy per-class box suppression
// Box and score store with a run command that suppresses overlapping
// lower-scored boxes class by class, and read-back of surviving scores.
// ----------------------------------------------------------------------------
// Every accepted transaction (start high while busy is low) returns exactly
// one result on o_rsp, marked by o_valid for one cycle; the receiver cannot
// stall it. Box and score loads answer in the next cycle and leave busy low;
// a score read answers after S_READ has taken the registered memory read.
// A run holds busy high for as long as it takes: for each class the
// sequencer makes one scan over the first det_count slots to pick the top
// score, then one more scan per box kept as a suppressor. Each scan step
// reads the memories and then evaluates (S_B_RD, S_B_EV); a step that needs
// an overlap test adds three products on the shared multiplier. Taking on
// a new suppressor fetches its box (S_A_RD, S_A_LD) plus one product for
// its area. That single multiplier and the one score memory port set the
// run time. Reading a slot or score never loaded since reset returns an
// arbitrary value.
// ----------------------------------------------------------------------------
module per_class_box_suppression_unit
    import pcbs_pkg::*;
#(
    parameter int MAX_DETS    = MAX_DETS_DEF,
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_req,
    output logic        o_valid,
    output t_out        o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int DW   = $clog2(MAX_DETS);
    localparam int CW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int C    = COORD_BITS;
    localparam int WW   = C - 1;
    localparam int BOXW = 4 * C - 2;
    localparam int SW   = C + 3;
    localparam int IW   = 2 * C;
    localparam int AW   = 2 * C - 2;
    localparam int WA   = 2 * C + 1;
    localparam int ND   = (C + MAC_DIGIT - 1) / MAC_DIGIT;
    localparam int WB   = ND * MAC_DIGIT;
    localparam int PW   = WA + WB;
    localparam int NCW  = ($clog2(MAX_CLASSES + 1) > 8) ? $clog2(MAX_CLASSES + 1) : 8;

    t_state r_state, n_state;
    logic [15:0] r_thr;
    logic [7:0]  r_ncls;
    logic        r_valid, n_valid;
    t_out        r_rsp, n_rsp;
    logic [CW-1:0] r_cls, n_cls;
    logic [DW-1:0] r_last, n_last;
    logic [DW-1:0] r_b, n_b;
    logic [DW-1:0] r_a, n_a;
    logic [15:0]   r_as, n_as;
    logic          r_have_a, n_have_a;
    logic [DW-1:0] r_best, n_best;
    logic [15:0]   r_best_s, n_best_s;
    logic signed [C-1:0] r_acx, n_acx, r_acy, n_acy;
    logic [WW-1:0] r_aw, n_aw, r_ah, n_ah;
    logic [AW-1:0] r_area_a, n_area_a;
    logic [IW-1:0] r_inter, n_inter;

    // memory and multiplier hookup
    logic            box_we, box_re, sc_we, sc_re;
    logic [DW-1:0]   box_addr;
    logic [BOXW-1:0] box_wdata, box_q;
    logic [DW+CW-1:0] sc_addr;
    logic [15:0]     sc_wdata, sc_q;
    logic            mac_start, mac_done;
    logic [WA-1:0]   mac_a;
    logic [WB-1:0]   mac_b;
    logic [PW-1:0]   mac_prod;

    // decoded request
    logic [DW-1:0]   in_det;
    logic [CW-1:0]   in_cls;
    logic            det_ok, cls_ok;
    logic [NCW-1:0]  ncls_sat;

    // box b fields and overlap
    logic signed [C-1:0] bcx, bcy;
    logic [WW-1:0] bw, bh;
    logic signed [SW-1:0] la, ra, lb, rb, lx, hx, ox;
    logic signed [SW-1:0] ta, ua, tb, ub, ly, hy, oy;
    logic [C-1:0]  ox_u, oy_u;
    logic          after;
    logic [AW:0]   area_sum;
    logic [WA-1:0] dval;
    logic          exceed;
    logic          adv;

    assign in_det   = DW'(i_req.det_index);
    assign in_cls   = CW'(i_req.class_index);
    assign det_ok   = (32'(i_req.det_index) < MAX_DETS);
    assign cls_ok   = (32'(i_req.class_index) < MAX_CLASSES);
    assign ncls_sat = (32'(r_ncls) > MAX_CLASSES) ? NCW'(MAX_CLASSES) : NCW'(r_ncls);

    assign box_wdata = {C'(i_req.center_x), C'(i_req.center_y),
                        WW'(i_req.box_width), WW'(i_req.box_height)};

    assign bcx = box_q[BOXW-1 -: C];
    assign bcy = box_q[BOXW-1-C -: C];
    assign bw  = box_q[2*WW-1 -: WW];
    assign bh  = box_q[WW-1:0];

    // interval edges in doubled units
    always_comb begin
        la = (SW'(r_acx) <<< 1) - signed'(SW'(r_aw));
        ra = (SW'(r_acx) <<< 1) + signed'(SW'(r_aw));
        lb = (SW'(bcx) <<< 1) - signed'(SW'(bw));
        rb = (SW'(bcx) <<< 1) + signed'(SW'(bw));
        lx = (la > lb) ? la : lb;
        hx = (ra < rb) ? ra : rb;
        ox = hx - lx;
        ta = (SW'(r_acy) <<< 1) - signed'(SW'(r_ah));
        ua = (SW'(r_acy) <<< 1) + signed'(SW'(r_ah));
        tb = (SW'(bcy) <<< 1) - signed'(SW'(bh));
        ub = (SW'(bcy) <<< 1) + signed'(SW'(bh));
        ly = (ta > tb) ? ta : tb;
        hy = (ua < ub) ? ua : ub;
        oy = hy - ly;
        // disjoint on either axis: no intersection
        if (ox < 0 || oy < 0) begin
            ox_u = '0;
            oy_u = '0;
        end else begin
            ox_u = C'(ox);
            oy_u = C'(oy);
        end
    end

    // b comes after a in visit order: lower score, or equal score and higher slot
    assign after    = !r_have_a || (sc_q < r_as) || (sc_q == r_as && r_b > r_a);
    assign area_sum = (AW+1)'(r_area_a) + (AW+1)'(AW'(mac_prod));
    assign dval     = {area_sum, 2'b00} - WA'(r_inter);
    assign exceed   = PW'({r_inter, 16'h0000}) > mac_prod;

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        n_cls     = r_cls;
        n_last    = r_last;
        n_b       = r_b;
        n_a       = r_a;
        n_as      = r_as;
        n_have_a  = r_have_a;
        n_best    = r_best;
        n_best_s  = r_best_s;
        n_acx     = r_acx;
        n_acy     = r_acy;
        n_aw      = r_aw;
        n_ah      = r_ah;
        n_area_a  = r_area_a;
        n_inter   = r_inter;
        box_we    = 1'b0;
        box_re    = 1'b0;
        box_addr  = r_b;
        sc_we     = 1'b0;
        sc_re     = 1'b0;
        sc_addr   = {r_b, r_cls};
        sc_wdata  = '0;
        mac_start = 1'b0;
        mac_a     = '0;
        mac_b     = '0;
        adv       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rsp = '{score_out: 16'h0000, status: STS_OK};
                    case (i_req.req_type)
                        REQ_RUN: begin
                            if (32'(i_req.det_count) > MAX_DETS) begin
                                n_rsp.status = STS_ERR;
                                n_valid      = 1'b1;
                            end else if (i_req.det_count == '0 || ncls_sat == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_last   = DW'(i_req.det_count - 9'd1);
                                n_cls    = '0;
                                n_have_a = 1'b0;
                                n_b      = '0;
                                n_best_s = '0;
                                n_state  = S_B_RD;
                            end
                        end
                        REQ_LOAD_BOX: begin
                            n_valid = 1'b1;
                            if (!det_ok) begin
                                n_rsp.status = STS_ERR;
                            end else begin
                                box_we   = 1'b1;
                                box_addr = in_det;
                            end
                        end
                        REQ_LOAD_SCORE: begin
                            n_valid = 1'b1;
                            if (!det_ok || !cls_ok) begin
                                n_rsp.status = STS_ERR;
                            end else begin
                                sc_we    = 1'b1;
                                sc_addr  = {in_det, in_cls};
                                sc_wdata = i_req.score_in;
                            end
                        end
                        REQ_READ: begin
                            if (!det_ok || !cls_ok) begin
                                n_rsp.status = STS_ERR;
                                n_valid      = 1'b1;
                            end else begin
                                sc_re   = 1'b1;
                                sc_addr = {in_det, in_cls};
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_rsp   = '{score_out: sc_q, status: STS_OK};
                n_state = S_IDLE;
            end
            S_A_RD: begin
                box_re   = 1'b1;
                box_addr = r_a;
                n_state  = S_A_LD;
            end
            S_A_LD: begin
                // hold the suppressing box and start its area
                n_acx     = bcx;
                n_acy     = bcy;
                n_aw      = bw;
                n_ah      = bh;
                mac_start = 1'b1;
                mac_a     = WA'(bw);
                mac_b     = WB'(bh);
                n_state   = S_A_AREA;
            end
            S_A_AREA: begin
                if (mac_done) begin
                    n_area_a = AW'(mac_prod);
                    n_b      = '0;
                    n_best_s = '0;
                    n_state  = S_B_RD;
                end
            end
            S_B_RD: begin
                box_re  = 1'b1;
                sc_re   = 1'b1;
                n_state = S_B_EV;
            end
            S_B_EV: begin
                if (after && r_have_a && sc_q != '0) begin
                    mac_start = 1'b1;
                    mac_a     = WA'(ox_u);
                    mac_b     = WB'(oy_u);
                    n_state   = S_M_INT;
                end else begin
                    if (after && sc_q > r_best_s) begin
                        n_best   = r_b;
                        n_best_s = sc_q;
                    end
                    adv = 1'b1;
                end
            end
            S_M_INT: begin
                if (mac_done) begin
                    n_inter   = IW'(mac_prod);
                    mac_start = 1'b1;
                    mac_a     = WA'(bw);
                    mac_b     = WB'(bh);
                    n_state   = S_M_AREA;
                end
            end
            S_M_AREA: begin
                if (mac_done) begin
                    // threshold times four times the union side of the test
                    mac_start = 1'b1;
                    mac_a     = dval;
                    mac_b     = WB'(r_thr);
                    n_state   = S_M_THR;
                end
            end
            S_M_THR: begin
                if (mac_done) begin
                    if (exceed) begin
                        sc_we    = 1'b1;
                        sc_wdata = '0;
                    end else if (sc_q > r_best_s) begin
                        n_best   = r_b;
                        n_best_s = sc_q;
                    end
                    adv = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance the scan, pick the next suppressor, move to the next class or end the run
        if (adv) begin
            if (r_b == r_last) begin
                if (n_best_s != '0) begin
                    n_a      = n_best;
                    n_as     = n_best_s;
                    n_have_a = 1'b1;
                    n_state  = S_A_RD;
                end else if ((NCW'(r_cls) + 1'b1) == ncls_sat) begin
                    n_valid = 1'b1;
                    n_rsp   = '{score_out: 16'h0000, status: STS_OK};
                    n_state = S_IDLE;
                end else begin
                    n_cls    = r_cls + 1'b1;
                    n_have_a = 1'b0;
                    n_b      = '0;
                    n_best_s = '0;
                    n_state  = S_B_RD;
                end
            end else begin
                n_b     = r_b + 1'b1;
                n_state = S_B_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_have_a <= 1'b0;
            r_thr    <= THR_RESET;
            r_ncls   <= NCLS_RESET;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_have_a <= n_have_a;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IOU_THR) begin
                    r_thr <= i_cfg_data;
                end else if (i_cfg_idx == CFG_NUM_CLS) begin
                    r_ncls <= i_cfg_data[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp    <= n_rsp;
        r_cls    <= n_cls;
        r_last   <= n_last;
        r_b      <= n_b;
        r_a      <= n_a;
        r_as     <= n_as;
        r_best   <= n_best;
        r_best_s <= n_best_s;
        r_acx    <= n_acx;
        r_acy    <= n_acy;
        r_aw     <= n_aw;
        r_ah     <= n_ah;
        r_area_a <= n_area_a;
        r_inter  <= n_inter;
    end

    pcbs_mem #(
        .DW   (DW),
        .CW   (CW),
        .BOXW (BOXW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_box_we    (box_we),
        .i_box_re    (box_re),
        .i_box_addr  (box_addr),
        .i_box_wdata (box_wdata),
        .o_box_q     (box_q),
        .i_sc_we     (sc_we),
        .i_sc_re     (sc_re),
        .i_sc_addr   (sc_addr),
        .i_sc_wdata  (sc_wdata),
        .o_sc_q      (sc_q)
    );

    pcbs_mac #(
        .WA (WA),
        .WB (WB)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_prod  (mac_prod)
    );

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    // a run only ever clears scores
    a_run_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sc_we && r_state != S_IDLE) |-> (sc_wdata == '0))
        else $error("nonzero score write during run");

    // a suppressor always carries a nonzero score
    a_suppressor_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have_a && r_state != S_IDLE) |-> (r_as != '0))
        else $error("suppressor with zero score");

    // an in-range read answers after passing through S_READ
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_READ && det_ok && cls_ok)
        |-> ##2 o_valid)
        else $error("read result missing");

    // the multiplier is only started from a state that consumes its result
    a_mac_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_start |=> (r_state == S_A_AREA || r_state == S_M_INT ||
                       r_state == S_M_AREA || r_state == S_M_THR))
        else $error("multiplier started outside a product state");
`endif

endmodule

[tb/box_suppression_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_suppression_checker: response predictor and scoreboard
// Watches the request, result and register channels of the suppression unit,
// keeps its own copy of the box and score stores, and compares every result
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module box_suppression_checker
    import pcbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_in         i_req,
    input  logic        i_valid,
    input  t_out        i_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NDETS = MAX_DETS_DEF;
    localparam int NCLS  = MAX_CLASSES_DEF;

    longint      box_cx [NDETS];
    longint      box_cy [NDETS];
    longint      box_w  [NDETS];
    longint      box_h  [NDETS];
    logic [15:0] score_mem [NDETS][NCLS];
    logic [15:0] iou_thr;
    logic [7:0]  class_limit;
    t_out        expected_rsp [$];
    int          fail_count;
    int          pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic longint span2(longint ca, longint wa, longint cb, longint wb);
        longint lo, hi;
        lo = (2 * ca - wa > 2 * cb - wb) ? 2 * ca - wa : 2 * cb - wb;
        hi = (2 * ca + wa < 2 * cb + wb) ? 2 * ca + wa : 2 * cb + wb;
        return hi - lo;
    endfunction

    // inter * (1 + thr) > thr * (areaA + areaB), all in doubled coordinates
    function automatic bit overlap_too_high(int a, int b);
        longint ox, oy, inter4, area_sum;
        ox = span2(box_cx[a], box_w[a], box_cx[b], box_w[b]);
        oy = span2(box_cy[a], box_h[a], box_cy[b], box_h[b]);
        inter4 = (ox >= 0 && oy >= 0) ? ox * oy : 0;
        area_sum = box_w[a] * box_h[a] + box_w[b] * box_h[b];
        return inter4 * (65536 + longint'(iou_thr)) > area_sum * 4 * longint'(iou_thr);
    endfunction

    task automatic suppress_class(int k, int n);
        int order [NDETS];
        int i, j;
        logic [15:0] s;
        // stable descending sort, ties keep slot order
        for (i = 0; i < n; i++) begin
            s = score_mem[i][k];
            j = i;
            while (j > 0 && score_mem[order[j-1]][k] < s) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < n; i++) begin
            if (score_mem[order[i]][k] != 0) begin
                for (j = i + 1; j < n; j++)
                    if (overlap_too_high(order[i], order[j]))
                        score_mem[order[j]][k] = '0;
            end
        end
    endtask

    task automatic predict_request(t_in r);
        t_out rsp;
        int   kc;
        rsp = '{score_out: '0, status: STS_OK};
        case (r.req_type)
            REQ_RUN: begin
                if (int'(r.det_count) > NDETS) begin
                    rsp.status = STS_ERR;
                end else begin
                    kc = (int'(class_limit) > NCLS) ? NCLS : int'(class_limit);
                    for (int k = 0; k < kc; k++)
                        suppress_class(k, int'(r.det_count));
                end
            end
            REQ_LOAD_BOX: begin
                box_cx[r.det_index] = longint'(r.center_x);
                box_cy[r.det_index] = longint'(r.center_y);
                box_w[r.det_index]  = longint'(r.box_width);
                box_h[r.det_index]  = longint'(r.box_height);
            end
            REQ_LOAD_SCORE: score_mem[r.det_index][r.class_index] = r.score_in;
            default: rsp.score_out = score_mem[r.det_index][r.class_index];
        endcase
        expected_rsp = {expected_rsp, rsp};
    endtask

    always @(posedge i_clk) begin
        t_out exp_rsp;
        if (!i_rst_n) begin
            iou_thr     = THR_RESET;
            class_limit = NCLS_RESET;
            expected_rsp.delete();
            fail_count  = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IOU_THR) iou_thr = i_cfg_data;
                else class_limit = i_cfg_data[7:0];
            end
            if (start && !busy) predict_request(i_req);
            if (i_valid) begin
                if (expected_rsp.size() == 0) begin
                    $error("unexpected result: score_out %0d status %0d",
                           i_rsp.score_out, i_rsp.status);
                    fail_count++;
                end else begin
                    exp_rsp = expected_rsp.pop_front();
                    if (i_rsp.score_out !== exp_rsp.score_out) begin
                        $error("score_out: expected %0d, actual %0d",
                               exp_rsp.score_out, i_rsp.score_out);
                        fail_count++;
                    end
                    if (i_rsp.status !== exp_rsp.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_rsp.status, i_rsp.status);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_rsp.size();
    end

endmodule

[tb/per_class_box_suppression_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_box_suppression_unit_tb: top of the suppression unit testbench
// Loads boxes and scores, runs suppression under several threshold and
// class-count settings, and reads the surviving scores back; a separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module per_class_box_suppression_unit_tb;
    import pcbs_pkg::*;

    localparam int IDLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_req;
    logic        o_valid;
    t_out        o_rsp;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          item_count;
    bit          burst_mode;
    bit          sparse_scores;

    per_class_box_suppression_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    box_suppression_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .i_valid(o_valid), .i_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort when no transaction moves in either direction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Fill every field with noise so that ignored bits toggle too.
    function automatic t_in noisy_req(t_req kind);
        logic [127:0] noise;
        t_in r;
        noise = {$urandom, $urandom, $urandom, $urandom};
        r = noise[$bits(t_in)-1:0];
        r.req_type = kind;
        return r;
    endfunction

    // Present one transaction after a random gap, or none in burst mode, hold until accepted.
    // Start stays high afterwards so back-to-back items need no lowering.
    task automatic send(t_in r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        item_count++;
    endtask

    // Hold off the sender until every predicted result has come back,
    // then let the read pipeline settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (pending == 0) break;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_box(int d, int cx, int cy, int w, int h);
        t_in r;
        r = noisy_req(REQ_LOAD_BOX);
        r.det_index  = 8'(d);
        r.center_x   = 16'(cx);
        r.center_y   = 16'(cy);
        r.box_width  = 15'(w);
        r.box_height = 15'(h);
        send(r);
    endtask

    task automatic load_score(int d, int c, int s);
        t_in r;
        r = noisy_req(REQ_LOAD_SCORE);
        r.det_index   = 8'(d);
        r.class_index = 7'(c);
        r.score_in    = 16'(s);
        send(r);
    endtask

    task automatic read_score(int d, int c);
        t_in r;
        r = noisy_req(REQ_READ);
        r.det_index   = 8'(d);
        r.class_index = 7'(c);
        send(r);
    endtask

    task automatic run_suppression(int n);
        t_in r;
        r = noisy_req(REQ_RUN);
        r.det_count = 9'(n);
        send(r);
    endtask

    // Few distinct values so that ties and zero scores show up often.
    function automatic int pick_score();
        if (sparse_scores)
            return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 65535) : 0;
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 16'h4000;
            2: return 16'hffff;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // One phase: set registers, load a cluster of boxes and all scores the
    // run will touch, run, then read back surviving scores.
    task automatic run_phase(int ph);
        int n, eff, base_x, base_y, wmax;
        logic [15:0] thr;
        logic [15:0] ncls;
        case (ph % 4)
            0: thr = 16'd0;
            1: thr = 16'hffff;
            2: thr = THR_RESET;
            default: thr = 16'($urandom_range(0, 65535));
        endcase
        n = $urandom_range(1, 8);
        ncls = 16'($urandom_range(1, 4));
        sparse_scores = 1'b0;
        if (ph == 3) begin
            ncls = 16'd128;
            n = 3;
        end else if (ph == 7) begin
            ncls = 16'd0;
        end else if (ph == 9) begin
            ncls = {8'($urandom_range(0, 255)), 8'd200};  // saturates to max classes
            n = 2;
        end else if (ph == 5) begin
            ncls = 16'd1;
            n = 256;
            sparse_scores = 1'b1;
        end else if (ph % 6 == 1) begin
            ncls = 16'd1;
        end
        eff = (ncls[7:0] > 8'd128) ? 128 : int'(ncls[7:0]);
        write_reg(CFG_IOU_THR, thr);
        write_reg(CFG_NUM_CLS, ncls);
        burst_mode = ($urandom_range(0, 2) == 0);

        base_x = $urandom_range(0, 60000) - 30000;
        base_y = $urandom_range(0, 60000) - 30000;
        wmax = ($urandom_range(0, 1) == 0) ? 2000 : 12000;
        for (int d = 0; d < n; d++)
            load_box(d, base_x + $urandom_range(0, 1600) - 800,
                     base_y + $urandom_range(0, 1600) - 800,
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, wmax),
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, wmax));
        for (int d = 0; d < n; d++)
            for (int c = 0; c < eff; c++) begin
                load_score(d, c, pick_score());
                if ($urandom_range(0, 15) == 0) read_score(0, 0);
            end
        // an out-of-range count changes nothing
        if ($urandom_range(0, 2) == 0) run_suppression($urandom_range(257, 511));
        run_suppression(n);
        if (eff > 0)
            repeat (n * eff < 12 ? n * eff : 12)
                read_score($urandom_range(0, n - 1), $urandom_range(0, eff - 1));
        burst_mode = 1'b0;
    endtask

    initial begin
        int ph;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_IOU_THR;
        i_cfg_data = '0;
        item_count = 0;
        burst_mode = 1'b0;
        sparse_scores = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes at the end slots.
        load_box(0, -32768, 32767, 32767, 0);
        load_box(255, 32767, -32768, 0, 32767);
        load_score(0, 0, 65535);
        load_score(255, 127, 0);
        read_score(0, 0);
        read_score(255, 127);
        run_suppression(511);   // count out of range
        run_suppression(257);
        run_suppression(0);     // empty run
        // Identical boxes with tied scores, a disjoint box, a zero-area box.
        write_reg(CFG_NUM_CLS, 16'd1);
        load_box(0, 0, 0, 4096, 4096);
        load_box(1, 0, 0, 4096, 4096);
        load_box(2, 20000, 20000, 1000, 1000);
        load_box(3, 0, 0, 0, 0);
        load_score(0, 0, 1000);
        load_score(1, 0, 1000);
        load_score(2, 0, 0);
        load_score(3, 0, 65535);
        run_suppression(4);
        read_score(0, 0);
        read_score(1, 0);
        read_score(2, 0);
        read_score(3, 0);

        // Random phases until enough items have gone in.
        item_count = 0;
        ph = 0;
        while (item_count < 1000) begin
            run_phase(ph);
            ph++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/pcbs_pkg.sv
rtl/pcbs_mac.sv
rtl/pcbs_mem.sv
rtl/per_class_box_suppression_unit.sv
tb/box_suppression_checker.sv
tb/per_class_box_suppression_unit_tb.sv
